[design/bgc_pkg.sv]
// shared types and constants for the button gesture classifier
package bgc_pkg;

    // slot count limits
    localparam int NUM_BUTTONS_DEF = 4;
    localparam int MASK_BITS       = 4;

    // result queue depth (power of two, at least 2)
    localparam int RESULT_DEPTH = 4;

    // reset value of both time thresholds
    localparam logic [15:0] RESET_WINDOW_MS = 16'd250;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_ENABLED_MASK   = 2'd0;
    localparam logic [1:0] REG_DOUBLE_WINDOW  = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS_MIN = 2'd2;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_LEVEL = 1'b1;

    // gesture event codes
    typedef enum logic [2:0] {
        EV_PRESSED  = 3'd0,
        EV_DOUBLE   = 3'd1,
        EV_RELEASED = 3'd2,
        EV_LONG     = 3'd3,
        EV_CLICK    = 3'd4,
        EV_INVALID  = 3'd5
    } event_code_t;

    // input item
    typedef struct packed {
        logic        kind;
        logic [2:0]  button_index;
        logic        is_held;
        logic [15:0] elapsed_ms;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [2:0]  button_id;
        event_code_t event_code;
        logic        last;
    } evt_item_t;

    // saturating 16-bit add
    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add16 = s[16] ? 16'hFFFF : s[15:0];
        end
    endfunction

endpackage

[design/button_gesture_classifier.sv]
// top level: per-slot gesture state, config registers and result queue
// the results of an accepted item are written into the result queue and leave it in order
// throughput: one item per cycle while the queue has room for two results; a release gives
// two results, so a stream of releases runs at the output rate of one result per cycle
// reset: mask cleared, both thresholds 250 ms, all slot state and queue cleared
module button_gesture_classifier #(
    parameter int NUM_BUTTONS = bgc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  bgc_pkg::req_item_t            req,
    output logic                          evt_valid,
    input  logic                          evt_ready,
    output bgc_pkg::evt_item_t            evt,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgc_pkg::PADDR_W-1:0]   paddr,
    input  logic [bgc_pkg::PDATA_W-1:0]   pwdata,
    output logic [bgc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bgc_pkg::*;

    localparam int NumSlots = (NUM_BUTTONS < MASK_BITS) ? NUM_BUTTONS : MASK_BITS;

    // configuration registers
    logic [MASK_BITS-1:0] mask_reg;
    logic [15:0]          window_reg;
    logic [15:0]          long_min_reg;

    // per-slot state
    logic                 held_flag_reg [NumSlots];
    logic [15:0]          held_time_reg [NumSlots];
    logic [15:0]          since_rel_reg [NumSlots];

    logic                 cfg_wr;
    logic [1:0]           cfg_idx;
    logic                 req_fire;
    logic                 tick_fire;
    logic                 level_fire;
    logic                 slot_ok;
    logic                 sel_held;
    logic [15:0]          sel_held_time;
    logic [15:0]          sel_since;
    logic                 is_press;
    logic                 is_release;
    logic                 is_double;
    logic                 is_long;
    logic [1:0]           push_cnt;
    evt_item_t            push_first;
    evt_item_t            push_second;
    logic                 room2;

    // handshakes
    assign pready     = 1'b1;
    assign cfg_idx    = paddr[3:2];
    assign cfg_wr     = psel && penable && pwrite;
    assign req_ready  = room2;
    assign req_fire   = req_valid && req_ready;
    assign tick_fire  = req_fire && (req.kind == KIND_TICK);
    assign level_fire = req_fire && (req.kind == KIND_LEVEL);

    // register read
    always_comb
    begin
        unique case (cfg_idx)
            REG_ENABLED_MASK:   prdata = PDATA_W'(mask_reg);
            REG_DOUBLE_WINDOW:  prdata = PDATA_W'(window_reg);
            REG_LONG_PRESS_MIN: prdata = PDATA_W'(long_min_reg);
            default:            prdata = '0;
        endcase
    end

    // addressed slot lookup
    always_comb
    begin
        slot_ok       = 1'b0;
        sel_held      = 1'b0;
        sel_held_time = '0;
        sel_since     = '0;
        for (int i = 0; i < NumSlots; i++)
        begin
            if (req.button_index == 3'(i))
            begin
                slot_ok       = mask_reg[i];
                sel_held      = held_flag_reg[i];
                sel_held_time = held_time_reg[i];
                sel_since     = since_rel_reg[i];
            end
        end
    end

    // gesture classification
    assign is_press   = slot_ok && !sel_held && req.is_held;
    assign is_release = slot_ok && sel_held && !req.is_held;
    assign is_double  = (sel_since < window_reg);
    assign is_long    = (sel_held_time >= long_min_reg);

    always_comb
    begin
        push_cnt               = 2'd0;
        push_first.button_id   = req.button_index;
        push_first.event_code  = EV_INVALID;
        push_first.last        = 1'b1;
        push_second.button_id  = req.button_index;
        push_second.event_code = is_long ? EV_LONG : EV_CLICK;
        push_second.last       = 1'b1;
        if (level_fire)
        begin
            priority if (!slot_ok)
            begin
                push_cnt = 2'd1;
            end
            else if (is_press)
            begin
                push_cnt              = 2'd1;
                push_first.event_code = is_double ? EV_DOUBLE : EV_PRESSED;
            end
            else if (is_release)
            begin
                push_cnt              = 2'd2;
                push_first.event_code = EV_RELEASED;
                push_first.last       = 1'b0;
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            window_reg   <= RESET_WINDOW_MS;
            long_min_reg <= RESET_WINDOW_MS;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ENABLED_MASK:   mask_reg     <= pwdata[MASK_BITS-1:0];
                REG_DOUBLE_WINDOW:  window_reg   <= pwdata[15:0];
                REG_LONG_PRESS_MIN: long_min_reg <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    // per-slot state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumSlots; i++)
            begin
                held_flag_reg[i] <= 1'b0;
                held_time_reg[i] <= '0;
                since_rel_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NumSlots; i++)
            begin
                if (cfg_wr && (cfg_idx == REG_ENABLED_MASK) && pwdata[i] && !mask_reg[i])
                begin
                    // newly enabled slot starts released
                    held_flag_reg[i] <= 1'b0;
                    held_time_reg[i] <= '0;
                end
                else if (tick_fire && mask_reg[i])
                begin
                    if (held_flag_reg[i])
                    begin
                        held_time_reg[i] <= sat_add16(held_time_reg[i], req.elapsed_ms);
                    end
                    else
                    begin
                        since_rel_reg[i] <= sat_add16(since_rel_reg[i], req.elapsed_ms);
                    end
                end
                else if (level_fire && (req.button_index == 3'(i)))
                begin
                    if (is_press)
                    begin
                        held_flag_reg[i] <= 1'b1;
                        held_time_reg[i] <= '0;
                        if (is_double)
                        begin
                            since_rel_reg[i] <= '0;
                        end
                    end
                    else if (is_release)
                    begin
                        held_flag_reg[i] <= 1'b0;
                        held_time_reg[i] <= '0;
                        since_rel_reg[i] <= '0;
                    end
                end
            end
        end
    end

    // result queue
    bgc_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (push_cnt),
        .push_first  (push_first),
        .push_second (push_second),
        .room2       (room2),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt         (evt)
    );

endmodule

[design/bgc_result_fifo.sv]
// result queue: takes up to two items per cycle, delivers one
module bgc_result_fifo #(
    parameter int DEPTH = bgc_pkg::RESULT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  bgc_pkg::evt_item_t push_first,
    input  bgc_pkg::evt_item_t push_second,
    output logic              room2,
    output logic              evt_valid,
    input  logic              evt_ready,
    output bgc_pkg::evt_item_t evt
);
    import bgc_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    evt_item_t         mem [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              pop;

    // handshake and status
    assign pop       = evt_valid && evt_ready;
    assign evt_valid = (count_reg != '0);
    assign evt       = mem[rd_ptr_reg];
    assign room2     = (count_reg <= CntW'(DEPTH - 2));

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + CntW'(push_cnt) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + PtrW'(1)] <= push_second;
        end
    end

endmodule

[dv/button_gesture_classifier_tb.sv]
// self-checking testbench for the button gesture classifier: random items, live prediction
module button_gesture_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgc_pkg::*;

    localparam int SLOTS          = NUM_BUTTONS_DEF;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 120;
    localparam int REPORT_MAX     = 10;
    // register index past the end of the map, writes to it are dropped
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_item_t            req       = '0;
    logic                 evt_valid;
    logic                 evt_ready = 1'b0;
    evt_item_t            evt;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // predicted block state and settings
    logic [3:0]  slot_mask;
    logic [15:0] dbl_window_ms;
    logic [15:0] long_min_ms;
    bit          slot_held [SLOTS];
    logic [15:0] held_ms [SLOTS];
    logic [15:0] idle_ms [SLOTS];

    // held levels as the generator expects them after its queued items
    bit          gen_held [SLOTS];

    req_item_t   items_to_send [$];
    evt_item_t   events_due [$];

    int items_sent;
    int random_items;
    int events_checked;
    int reg_writes;
    int mismatches;
    int quiet_cycles;
    int code_seen [6];

    // driver and receiver pacing
    bit offer_open;
    bit tx_steady;
    bit rx_steady;
    int gap_left;
    int wait_left;
    int hold_left;
    bit hold_done;

    button_gesture_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    // time counters stop at all ones
    function automatic logic [15:0] add_capped(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void expect_event(input logic [2:0] id, input event_code_t code,
                                         input logic last);
        evt_item_t e;
        e.button_id  = id;
        e.event_code = code;
        e.last       = last;
        events_due.push_back(e);
    endfunction

    // gesture prediction for one accepted item
    function automatic void classify_item(input req_item_t it);
        int s;
        logic [1:0] slot;
        slot = it.button_index[1:0];
        if (it.kind == KIND_TICK)
        begin
            for (s = 0; s < SLOTS; s++)
            begin
                if (slot_mask[s])
                begin
                    if (slot_held[s])
                        held_ms[s] = add_capped(held_ms[s], it.elapsed_ms);
                    else
                        idle_ms[s] = add_capped(idle_ms[s], it.elapsed_ms);
                end
            end
        end
        else if (it.button_index >= SLOTS || !slot_mask[slot])
        begin
            expect_event(it.button_index, EV_INVALID, 1'b1);
        end
        else if (!slot_held[slot] && it.is_held)
        begin
            slot_held[slot] = 1'b1;
            held_ms[slot]   = '0;
            if (idle_ms[slot] < dbl_window_ms)
            begin
                idle_ms[slot] = '0;
                expect_event(it.button_index, EV_DOUBLE, 1'b1);
            end
            else
                expect_event(it.button_index, EV_PRESSED, 1'b1);
        end
        else if (slot_held[slot] && !it.is_held)
        begin
            expect_event(it.button_index, EV_RELEASED, 1'b0);
            expect_event(it.button_index,
                         (held_ms[slot] >= long_min_ms) ? EV_LONG : EV_CLICK, 1'b1);
            slot_held[slot] = 1'b0;
            held_ms[slot]   = '0;
            idle_ms[slot]   = '0;
        end
    endfunction

    // register write as the block sees it; newly enabled slots start released
    function automatic void apply_reg_write(input logic [1:0] idx, input logic [31:0] value);
        int s;
        logic [3:0] rising;
        case (idx)
            REG_ENABLED_MASK:
            begin
                rising = value[3:0] & ~slot_mask;
                for (s = 0; s < SLOTS; s++)
                begin
                    if (rising[s])
                    begin
                        slot_held[s] = 1'b0;
                        held_ms[s]   = '0;
                    end
                end
                slot_mask = value[3:0];
            end
            REG_DOUBLE_WINDOW:  dbl_window_ms = value[15:0];
            REG_LONG_PRESS_MIN: long_min_ms   = value[15:0];
            default: ;
        endcase
    endfunction

    // compare one result with the oldest prediction
    function automatic void check_event(input evt_item_t got);
        evt_item_t want;
        events_checked++;
        if (events_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: unexpected result id %0d code %0d last %0d",
                         $time, got.button_id, got.event_code, got.last);
        end
        else
        begin
            want = events_due.pop_front();
            code_seen[int'(want.event_code)]++;
            if (got.button_id !== want.button_id || got.event_code !== want.event_code ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $write("%0t: result %0d: expected id %0d code %0d last %0d, ",
                           $time, events_checked, want.button_id, want.event_code,
                           want.last);
                    $display("got id %0d code %0d last %0d",
                             got.button_id, got.event_code, got.last);
                end
            end
        end
    endfunction

    // sender: one item at a time from the queue, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                classify_item(req);
                items_sent++;
                offer_open = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    tx_steady = !tx_steady;
                gap_left = tx_steady ? 0 : $urandom_range(0, 5);
            end
            if (!offer_open)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (items_to_send.size() != 0)
                begin
                    req        <= items_to_send.pop_front();
                    req_valid  <= 1'b1;
                    offer_open = 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: checks results, random stalls and one long hold to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_ready <= 1'b0;
        else
        begin
            if (evt_valid && evt_ready)
            begin
                check_event(evt);
                if ($urandom_range(0, 49) == 0)
                    rx_steady = !rx_steady;
                wait_left = rx_steady ? 0 : $urandom_range(0, 5);
                if (!hold_done && events_checked >= HOLD_AFTER && items_to_send.size() > 20)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                evt_ready <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                evt_ready <= 1'b0;
            end
            else
                evt_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (evt_valid && evt_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results still expected",
                         $time, quiet_cycles, events_due.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_reg_write(idx, value);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block drained: nothing queued, nothing offered, nothing expected
    task automatic wait_idle();
        while (items_to_send.size() != 0 || offer_open || events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_tick(input logic [15:0] ms);
        req_item_t it;
        it.kind         = KIND_TICK;
        it.button_index = '0;
        it.is_held      = 1'b0;
        it.elapsed_ms   = ms;
        items_to_send.push_back(it);
    endtask

    task automatic queue_level(input logic [2:0] idx, input logic held, input logic [15:0] ms);
        req_item_t it;
        it.kind         = KIND_LEVEL;
        it.button_index = idx;
        it.is_held      = held;
        it.elapsed_ms   = ms;
        items_to_send.push_back(it);
    endtask

    // mostly press/release toggles with ticks in between, some repeats and bad indexes
    task automatic queue_random(input int count, input int span);
        req_item_t it;
        int n;
        int r;
        logic [1:0] s;
        for (n = 0; n < count; n++)
        begin
            r             = $urandom_range(0, 99);
            it.elapsed_ms = 16'($urandom_range(0, 65535));
            it.is_held    = 1'($urandom_range(0, 1));
            if (r < 40)
            begin
                it.kind         = KIND_TICK;
                it.button_index = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 6) != 0)
                    it.elapsed_ms = 16'($urandom_range(0, span));
            end
            else if (r < 92)
            begin
                s               = 2'($urandom_range(0, SLOTS - 1));
                it.kind         = KIND_LEVEL;
                it.button_index = {1'b0, s};
                it.is_held      = ($urandom_range(0, 99) < 85) ? !gen_held[s] : gen_held[s];
                if (slot_mask[s])
                    gen_held[s] = it.is_held;
            end
            else
            begin
                it.kind         = KIND_LEVEL;
                it.button_index = 3'($urandom_range(SLOTS, 7));
            end
            items_to_send.push_back(it);
            random_items++;
        end
    endtask

    // new settings, then a batch of random items run to completion
    task automatic run_phase(input logic [3:0] mask, input logic [15:0] window,
                             input logic [15:0] hold_min, input int span, input int count);
        int s;
        reg_write(REG_ENABLED_MASK, {28'd0, mask});
        reg_write(REG_DOUBLE_WINDOW, {16'd0, window});
        reg_write(REG_LONG_PRESS_MIN, {16'd0, hold_min});
        for (s = 0; s < SLOTS; s++)
            gen_held[s] = slot_held[s];
        queue_random(count, span);
        wait_idle();
    endtask

    initial
    begin
        slot_mask     = '0;
        dbl_window_ms = RESET_WINDOW_MS;
        long_min_ms   = RESET_WINDOW_MS;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_held[s] = 1'b0;
            held_ms[s]   = '0;
            idle_ms[s]   = '0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // out of reset every slot is disabled, so every level update is refused
        queue_level(3'd0, 1'b1, 16'h0000);
        queue_level(3'd3, 1'b0, 16'hFFFF);
        queue_level(3'd7, 1'b1, 16'h0000);
        queue_tick(16'hFFFF);
        wait_idle();

        // unmapped register must leave everything alone, then enable all slots
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        reg_write(REG_ENABLED_MASK, 32'h0000_000F);

        // directed gestures at the reset thresholds
        queue_level(3'd0, 1'b1, 16'h0000);   // press right after reset: double click
        queue_tick(16'd300);
        queue_level(3'd0, 1'b0, 16'h0000);   // long press
        queue_level(3'd0, 1'b0, 16'h0000);   // same level again, ignored
        queue_tick(16'd100);
        queue_level(3'd0, 1'b1, 16'h0000);   // inside the window
        queue_tick(16'd249);
        queue_level(3'd0, 1'b0, 16'h0000);   // one short of the threshold: click
        queue_tick(16'd250);
        queue_level(3'd0, 1'b1, 16'h0000);   // exactly at the window: plain press
        queue_level(3'd0, 1'b1, 16'h0000);
        queue_tick(16'hFFFF);
        queue_tick(16'hFFFF);                // counters pinned at all ones
        queue_level(3'd0, 1'b0, 16'h0000);
        queue_level(3'd1, 1'b1, 16'h0000);
        queue_level(3'd1, 1'b0, 16'h0000);
        queue_level(3'd4, 1'b1, 16'h0000);   // indexes past the slots
        queue_level(3'd6, 1'b0, 16'h0000);
        queue_level(3'd7, 1'b1, 16'hFFFF);
        queue_tick(16'h0000);
        queue_level(3'd3, 1'b1, 16'hA5A5);   // left held across the next mask change
        wait_idle();

        // random phases: zero and full-scale thresholds, partial masks, re-enabled slots
        run_phase(4'b0101, 16'd0, 16'd0, 40, 235);
        run_phase(4'b1111, 16'hFFFF, 16'hFFFF, 30000, 235);
        run_phase(4'($urandom_range(1, 15)), 16'($urandom_range(1, 600)),
                  16'($urandom_range(1, 600)), 400, 235);
        run_phase(4'b1011, 16'd200, 16'd350, 250, 240);

        repeat (10) @(posedge clk);
        mismatches += events_due.size();

        $write("%0d items sent (%0d random over four settings), ", items_sent, random_items);
        $display("%0d results checked, %0d register writes", events_checked, reg_writes);
        $display("pressed %0d, double %0d, released %0d, long %0d, click %0d, invalid %0d",
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4],
                 code_seen[5]);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
design/bgc_pkg.sv
design/bgc_result_fifo.sv
design/button_gesture_classifier.sv
dv/button_gesture_classifier_tb.sv
